@@ rtl/kmsw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kmsw_pkg;

  // field widths
  localparam int ACT_W  = 2;
  localparam int INS_W  = 8;
  localparam int KMER_W = 7;
  localparam int OUT_W  = 24;

  // defaults for the top level parameters
  localparam int MAX_KMER_DEF   = 64;
  localparam int COUNT_BITS_DEF = 24;

  // window length after reset
  localparam logic [KMER_W-1:0] KMER_RESET = 7'd21;

  // window classification sums
  localparam int SUM_SUB    = 2;
  localparam int SUM_DEL    = 3;
  localparam int INS_SINGLE = 1;

  // number of class counters
  localparam int NUM_CLASS = 6;

  // per-window classification of the current position
  typedef struct packed {
    logic sub_long;
    logic ins_long;
    logic del_long;
    logic sub_short;
    logic ins_short;
    logic del_short;
  } hit_t;

endpackage

`default_nettype wire

@@ rtl/kmsw_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kmsw_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

@@ rtl/kmsw_window.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kmsw_window #(
  parameter int MAX_KMER = kmsw_pkg::MAX_KMER_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [kmsw_pkg::KMER_W-1:0] cfg_wdata_i,
  input  wire logic                        step_i,
  input  wire logic                        last_i,
  input  wire logic [kmsw_pkg::ACT_W-1:0]  act_i,
  input  wire logic [kmsw_pkg::INS_W-1:0]  ins_i,
  output kmsw_pkg::hit_t                   hit_o
);

  localparam int ACT_W = kmsw_pkg::ACT_W;
  localparam int INS_W = kmsw_pkg::INS_W;
  localparam int DW    = ACT_W + INS_W;
  localparam int AW    = (MAX_KMER > 1) ? $clog2(MAX_KMER) : 1;
  localparam int KW    = $clog2(MAX_KMER + 1);
  localparam int SW    = AW + 2;
  localparam int AS_W  = $clog2(3 * MAX_KMER + 1);
  localparam int IS_W  = $clog2(255 * MAX_KMER + 1);

  logic [kmsw_pkg::KMER_W-1:0] kmer_q, kmer_d;
  logic [AW-1:0]   wp_q, wp_d;
  logic [KW-1:0]   pc_q, pc_d, pc_inc;
  logic [AS_W-1:0] la_q, la_d, la_new, sa_q, sa_d, sa_new;
  logic [IS_W-1:0] li_q, li_d, li_new, si_q, si_d, si_new;
  logic [KW-1:0]   k_cur, s_cur, k_nxt, s_nxt;
  logic [AW-1:0]   raddr_l, raddr_s;
  logic [DW-1:0]   wdata, rdata_l, rdata_s, old_l, old_s;
  logic            byp_l_q, byp_s_q;
  logic [DW-1:0]   byp_data_q;
  logic            seq_clr, full_l_pre, full_s_pre, full_l_post, full_s_post;

  // clamp the configured length into 1..MAX_KMER
  function automatic logic [KW-1:0] clamp_k(input logic [kmsw_pkg::KMER_W-1:0] v);
    logic [KW-1:0] r;
    if (v == '0) begin
      r = KW'(1);
    end else if (int'(v) > MAX_KMER) begin
      r = KW'(MAX_KMER);
    end else begin
      r = KW'(v);
    end
    return r;
  endfunction

  // short window length (k+1)/2
  function automatic logic [KW-1:0] half_k(input logic [KW-1:0] k);
    logic [KW:0] t;
    t = ({1'b0, k} + 1'b1) >> 1;
    return KW'(t);
  endfunction

  // ring index of the entry k positions back from a pointer
  function automatic logic [AW-1:0] back_ptr(input logic [AW-1:0] wp, input logic [KW-1:0] k);
    logic [SW-1:0] t;
    t = SW'(wp) + SW'(MAX_KMER) - SW'(k);
    if (t >= SW'(MAX_KMER)) begin
      t = t - SW'(MAX_KMER);
    end
    return t[AW-1:0];
  endfunction

  assign seq_clr = cfg_we_i | (step_i & last_i);
  assign kmer_d  = cfg_we_i ? cfg_wdata_i : kmer_q;

  assign k_cur = clamp_k(kmer_q);
  assign s_cur = half_k(k_cur);
  assign k_nxt = clamp_k(kmer_d);
  assign s_nxt = half_k(k_nxt);

  // write pointer and saturating position count
  assign pc_inc = (pc_q == KW'(MAX_KMER)) ? pc_q : pc_q + 1'b1;

  always_comb begin
    wp_d = wp_q;
    pc_d = pc_q;
    if (seq_clr) begin
      wp_d = '0;
      pc_d = '0;
    end else if (step_i) begin
      wp_d = (wp_q == AW'(MAX_KMER - 1)) ? '0 : wp_q + 1'b1;
      pc_d = pc_inc;
    end
  end

  // read the leaving entries for the next position ahead of time
  assign raddr_l = back_ptr(wp_d, k_nxt);
  assign raddr_s = back_ptr(wp_d, s_nxt);
  assign wdata   = {act_i, ins_i};

  kmsw_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_KMER)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (step_i),
    .waddr_i   (wp_q),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_l),
    .raddr_b_i (raddr_s),
    .rdata_a_o (rdata_l),
    .rdata_b_o (rdata_s)
  );

  // forward an entry written in the same cycle it was read
  assign old_l = byp_l_q ? byp_data_q : rdata_l;
  assign old_s = byp_s_q ? byp_data_q : rdata_s;

  // running window sums
  assign full_l_pre  = pc_q >= k_cur;
  assign full_s_pre  = pc_q >= s_cur;
  assign full_l_post = pc_inc >= k_cur;
  assign full_s_post = pc_inc >= s_cur;

  always_comb begin
    la_new = la_q - (full_l_pre ? AS_W'(old_l[INS_W +: ACT_W]) : '0) + AS_W'(act_i);
    li_new = li_q - (full_l_pre ? IS_W'(old_l[INS_W-1:0]) : '0) + IS_W'(ins_i);
    sa_new = sa_q - (full_s_pre ? AS_W'(old_s[INS_W +: ACT_W]) : '0) + AS_W'(act_i);
    si_new = si_q - (full_s_pre ? IS_W'(old_s[INS_W-1:0]) : '0) + IS_W'(ins_i);
    la_d = la_q;
    li_d = li_q;
    sa_d = sa_q;
    si_d = si_q;
    if (seq_clr) begin
      la_d = '0;
      li_d = '0;
      sa_d = '0;
      si_d = '0;
    end else if (step_i) begin
      la_d = la_new;
      li_d = li_new;
      sa_d = sa_new;
      si_d = si_new;
    end
  end

  // classify full windows
  always_comb begin
    hit_o.sub_long  = step_i & full_l_post & (la_new == AS_W'(kmsw_pkg::SUM_SUB))
                      & (li_new == '0);
    hit_o.ins_long  = step_i & full_l_post & (la_new == '0)
                      & (li_new == IS_W'(kmsw_pkg::INS_SINGLE));
    hit_o.del_long  = step_i & full_l_post & (la_new == AS_W'(kmsw_pkg::SUM_DEL))
                      & (li_new == '0);
    hit_o.sub_short = step_i & full_s_post & (sa_new == AS_W'(kmsw_pkg::SUM_SUB))
                      & (si_new == '0);
    hit_o.ins_short = step_i & full_s_post & (sa_new == '0)
                      & (si_new == IS_W'(kmsw_pkg::INS_SINGLE));
    hit_o.del_short = step_i & full_s_post & (sa_new == AS_W'(kmsw_pkg::SUM_DEL))
                      & (si_new == '0);
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_q  <= kmsw_pkg::KMER_RESET;
      wp_q    <= '0;
      pc_q    <= '0;
      la_q    <= '0;
      li_q    <= '0;
      sa_q    <= '0;
      si_q    <= '0;
      byp_l_q <= 1'b0;
      byp_s_q <= 1'b0;
    end else begin
      kmer_q  <= kmer_d;
      wp_q    <= wp_d;
      pc_q    <= pc_d;
      la_q    <= la_d;
      li_q    <= li_d;
      sa_q    <= sa_d;
      si_q    <= si_d;
      byp_l_q <= step_i & (raddr_l == wp_q);
      byp_s_q <= step_i & (raddr_s == wp_q);
    end
  end

  // forwarded data
  always_ff @(posedge clk_i) begin
    byp_data_q <= wdata;
  end

endmodule

`default_nettype wire

@@ rtl/kmsw_count.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kmsw_count #(
  parameter int COUNT_BITS = kmsw_pkg::COUNT_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       clear_i,
  input  wire logic                       step_i,
  input  wire logic                       last_i,
  input  wire kmsw_pkg::hit_t             hit_i,
  output logic [kmsw_pkg::OUT_W-1:0]      count_o [kmsw_pkg::NUM_CLASS]
);

  localparam int NC = kmsw_pkg::NUM_CLASS;
  localparam int OW = kmsw_pkg::OUT_W;

  logic [COUNT_BITS-1:0] cnt_q [NC];
  logic [COUNT_BITS-1:0] cnt_d [NC];
  logic [COUNT_BITS-1:0] bumped [NC];
  logic [NC-1:0]         hit_vec;

  // output order: long sub, ins, del, then short sub, ins, del
  assign hit_vec = {hit_i.del_short, hit_i.ins_short, hit_i.sub_short,
                    hit_i.del_long,  hit_i.ins_long,  hit_i.sub_long};

  // saturating increment, cleared at end of sequence or on reconfiguration
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      bumped[i] = (hit_vec[i] && (cnt_q[i] != '1)) ? cnt_q[i] + 1'b1 : cnt_q[i];
      if (clear_i || (step_i && last_i)) begin
        cnt_d[i] = '0;
      end else begin
        cnt_d[i] = bumped[i];
      end
      count_o[i] = OW'(bumped[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NC; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NC; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/kmer_single_mutation_window_counter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Counts single-mutation windows over a stream of sequence positions. Each
// request carries one position's action code and insertion length; a long
// window of k positions and a short window of (k+1)/2 positions slide over
// the positions of the current sequence, and every full window whose sums
// show exactly one substitution, deletion or single-base insertion bumps a
// saturating counter. The request marked last returns the six counts and
// starts a new sequence. One position is taken every clock unless a last
// request waits for a busy output register; the leaving window entries are
// read ahead from a dual-read ring memory, so the running sums update
// between the input register and the result register. A result may wait
// in the output register while new requests flow in. Writing kmer_size
// (clamped to 1..MAX_KMER) abandons the current sequence and clears all
// counts; write it only while no request is in flight.
module kmer_single_mutation_window_counter_unit #(
  parameter int MAX_KMER   = kmsw_pkg::MAX_KMER_DEF,
  parameter int COUNT_BITS = kmsw_pkg::COUNT_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [kmsw_pkg::KMER_W-1:0] cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [kmsw_pkg::ACT_W-1:0]  action_i,
  input  wire logic [kmsw_pkg::INS_W-1:0]  insert_len_i,
  input  wire logic                        is_last_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [kmsw_pkg::OUT_W-1:0]       sub_long_o,
  output logic [kmsw_pkg::OUT_W-1:0]       ins_long_o,
  output logic [kmsw_pkg::OUT_W-1:0]       del_long_o,
  output logic [kmsw_pkg::OUT_W-1:0]       sub_short_o,
  output logic [kmsw_pkg::OUT_W-1:0]       ins_short_o,
  output logic [kmsw_pkg::OUT_W-1:0]       del_short_o
);

  localparam int NC = kmsw_pkg::NUM_CLASS;
  localparam int OW = kmsw_pkg::OUT_W;

  logic                       s1_valid_q;
  logic [kmsw_pkg::ACT_W-1:0] s1_act_q;
  logic [kmsw_pkg::INS_W-1:0] s1_ins_q;
  logic                       s1_last_q;
  logic                       step, in_take, out_load;
  kmsw_pkg::hit_t             hit;
  logic [OW-1:0]              count [NC];
  logic [OW-1:0]              res_q [NC];

  // a position steps unless its result must wait for a busy output register
  assign step       = s1_valid_q & (~s1_last_q | ~out_valid_o | out_ready_i);
  assign in_ready_o = ~s1_valid_q | step;
  assign in_take    = in_valid_i & in_ready_o;
  assign out_load   = step & s1_last_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_act_q  <= action_i;
      s1_ins_q  <= insert_len_i;
      s1_last_q <= is_last_i;
    end
  end

  // window sums and classification
  kmsw_window #(
    .MAX_KMER (MAX_KMER)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .last_i      (s1_last_q),
    .act_i       (s1_act_q),
    .ins_i       (s1_ins_q),
    .hit_o       (hit)
  );

  // class counters
  kmsw_count #(
    .COUNT_BITS (COUNT_BITS)
  ) u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_we_i),
    .step_i  (step),
    .last_i  (s1_last_q),
    .hit_i   (hit),
    .count_o (count)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int i = 0; i < NC; i++) begin
        res_q[i] <= count[i];
      end
    end
  end

  assign sub_long_o  = res_q[0];
  assign ins_long_o  = res_q[1];
  assign del_long_o  = res_q[2];
  assign sub_short_o = res_q[3];
  assign ins_short_o = res_q[4];
  assign del_short_o = res_q[5];

endmodule

`default_nettype wire
